// File: hdl/sab_pkg.sv
package sab_pkg;

   // Canvas and scale limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_SCALE  = 8;

   // Framebuffer geometry
   localparam int FB_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int FB_AW    = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
   localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SCW      = $clog2(MAX_SCALE + 1);

   // Signed working width for canvas coordinates before clipping
   localparam int CW = 16;

   // Register file
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_POS_X    = 3'd0;
   localparam logic [2:0] REG_POS_Y    = 3'd1;
   localparam logic [2:0] REG_SCALE_X  = 3'd2;
   localparam logic [2:0] REG_SCALE_Y  = 3'd3;
   localparam logic [2:0] REG_CANVAS_W = 3'd4;
   localparam logic [2:0] REG_CANVAS_H = 3'd5;

   // Operation codes
   localparam logic [1:0] OP_BLEND = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic        [1:0] operation;
      logic        [9:0] pix_x;
      logic        [9:0] pix_y;
      logic        [7:0] red;
      logic        [7:0] green;
      logic        [7:0] blue;
      logic        [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic signed [12:0] pos_x;
      logic signed [12:0] pos_y;
      logic        [3:0]  scale_x;
      logic        [3:0]  scale_y;
      logic        [8:0]  canvas_width;
      logic        [8:0]  canvas_height;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   // Framebuffer access from the sequencer
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [FB_AW-1:0] addr;
      pix_type          wdata;
   } fb_req_type;

endpackage

// File: hdl/sab_csr.sv
module sab_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sab_pkg::CSR_AW-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output sab_pkg::cfg_type              cfg
);

   sab_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr;

   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            sab_pkg::REG_POS_X:    cfg_in.pos_x         = pwdata[12:0];
            sab_pkg::REG_POS_Y:    cfg_in.pos_y         = pwdata[12:0];
            sab_pkg::REG_SCALE_X:  cfg_in.scale_x       = pwdata[3:0];
            sab_pkg::REG_SCALE_Y:  cfg_in.scale_y       = pwdata[3:0];
            sab_pkg::REG_CANVAS_W: cfg_in.canvas_width  = pwdata[8:0];
            sab_pkg::REG_CANVAS_H: cfg_in.canvas_height = pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x         <= '0;
         cfg_ff.pos_y         <= '0;
         cfg_ff.scale_x       <= 4'd1;
         cfg_ff.scale_y       <= 4'd1;
         cfg_ff.canvas_width  <= 9'd256;
         cfg_ff.canvas_height <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         sab_pkg::REG_POS_X:    prdata = {19'd0, cfg_ff.pos_x};
         sab_pkg::REG_POS_Y:    prdata = {19'd0, cfg_ff.pos_y};
         sab_pkg::REG_SCALE_X:  prdata = {28'd0, cfg_ff.scale_x};
         sab_pkg::REG_SCALE_Y:  prdata = {28'd0, cfg_ff.scale_y};
         sab_pkg::REG_CANVAS_W: prdata = {23'd0, cfg_ff.canvas_width};
         sab_pkg::REG_CANVAS_H: prdata = {23'd0, cfg_ff.canvas_height};
         default:               prdata = 32'd0;
      endcase
   end

endmodule

// File: hdl/sab_mix.sv
module sab_mix (
   input  logic [7:0] src,
   input  logic [7:0] dst,
   input  logic [7:0] alpha,
   output logic [7:0] result
);

   logic [16:0] num;
   logic [16:0] sum;

   // src*a + dst*(255-a), at most 255*255
   assign num = 17'(16'(src) * 16'(alpha)) + 17'(16'(dst) * 16'(8'd255 - alpha));

   // Exact divide by 255 for any numerator up to 255*255
   assign sum    = num + 17'd1 + 17'(num[16:8]);
   assign result = sum[15:8];

endmodule

// File: hdl/sab_fb.sv
module sab_fb (
   input  logic                 clock,
   input  logic                 reset,
   input  sab_pkg::fb_req_type  fb_req,
   output sab_pkg::pix_type     rdata,
   output logic                 busy
);

   sab_pkg::pix_type mem [sab_pkg::FB_DEPTH];
   sab_pkg::pix_type rdata_ff;

   logic [sab_pkg::FB_AW-1:0] clr_addr_ff, clr_addr_in;
   logic                      busy_ff, busy_in;

   logic                      we;
   logic [sab_pkg::FB_AW-1:0] waddr;
   sab_pkg::pix_type          wdata;

   assign busy  = busy_ff;
   assign rdata = rdata_ff;

   // Clearing sweep after reset, one entry per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == sab_pkg::FB_AW'(sab_pkg::FB_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         busy_ff     <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         busy_ff     <= busy_in;
      end
   end

   // Write port shared between sweep and sequencer
   assign we    = busy_ff || fb_req.wr_en;
   assign waddr = busy_ff ? clr_addr_ff : fb_req.addr;
   assign wdata = busy_ff ? '0 : fb_req.wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (fb_req.rd_en) begin
         rdata_ff <= mem[fb_req.addr];
      end
   end

endmodule

// File: hdl/scaled_alpha_blit_core.sv
// Channel  | Signals                                    | Direction
// ---------+--------------------------------------------+----------
// request  | req_valid, req_stall, req_data (req_type)  | in
// response | rsp_valid, rsp_stall, rsp_data (rsp_type)  | out
// control  | psel, penable, pwrite, paddr, pwdata,      | in/out
//          | prdata, pready                             |
//
// A blend passes through the setup and clip states, then for each covered canvas
// pixel does a framebuffer read, three passes through the shared channel blend
// unit and a write that also loads the response register. A load goes through
// setup and the emit state, a read through setup, a framebuffer read and the
// emit state; the next request is taken only once the sequencer is back in idle.
// After reset the framebuffer is swept to zero, one entry a cycle; no request is
// taken meanwhile, register writes are. A response beat waits in the output
// register; while it is stalled the write cycle of the next pixel holds.
module scaled_alpha_blit_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sab_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sab_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sab_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int CW  = sab_pkg::CW;
   localparam int XW  = sab_pkg::XW;
   localparam int YW  = sab_pkg::YW;
   localparam int SCW = sab_pkg::SCW;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_CLIP  = 6'b000100,
      ST_RD    = 6'b001000,
      ST_MIX   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   sab_pkg::cfg_type    cfg;
   sab_pkg::fb_req_type fb_req;
   sab_pkg::pix_type    fb_rdata;
   logic                fb_busy;

   state_type           state_ff, state_in;
   sab_pkg::req_type    item_ff, item_in;
   logic signed [CW-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [XW-1:0]       x_hi_ff, x_hi_in, cur_x_ff, cur_x_in;
   logic [YW-1:0]       y_lo_ff, y_lo_in, y_hi_ff, y_hi_in, cur_y_ff, cur_y_in;
   logic [1:0]          ch_ff, ch_in;
   sab_pkg::pix_type    res_ff, res_in;
   sab_pkg::rsp_type    rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic signed [CW-1:0] w_eff, h_eff;
   logic [SCW-1:0]      sx_eff, sy_eff;
   logic signed [CW-1:0] x0, x1, xe, y0, y1, ye;
   logic signed [CW-1:0] px_s, py_s;
   logic                accept, out_free, pix_last;
   logic [7:0]          mix_src, mix_dst, mix_out;
   sab_pkg::pix_type    emit_pix;

   sab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sab_fb u_fb (
      .clock  (clock),
      .reset  (reset),
      .fb_req (fb_req),
      .rdata  (fb_rdata),
      .busy   (fb_busy)
   );

   sab_mix u_mix (
      .src    (mix_src),
      .dst    (mix_dst),
      .alpha  (item_ff.alpha),
      .result (mix_out)
   );

   assign req_stall = (state_ff != ST_IDLE) || fb_busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Effective canvas size and scales
   always_comb begin
      w_eff = (int'(cfg.canvas_width) > sab_pkg::MAX_WIDTH) ?
              CW'(sab_pkg::MAX_WIDTH) : CW'(cfg.canvas_width);
      h_eff = (int'(cfg.canvas_height) > sab_pkg::MAX_HEIGHT) ?
              CW'(sab_pkg::MAX_HEIGHT) : CW'(cfg.canvas_height);
      if (cfg.scale_x == 4'd0) begin
         sx_eff = SCW'(1);
      end else if (int'(cfg.scale_x) > sab_pkg::MAX_SCALE) begin
         sx_eff = SCW'(sab_pkg::MAX_SCALE);
      end else begin
         sx_eff = SCW'(cfg.scale_x);
      end
      if (cfg.scale_y == 4'd0) begin
         sy_eff = SCW'(1);
      end else if (int'(cfg.scale_y) > sab_pkg::MAX_SCALE) begin
         sy_eff = SCW'(sab_pkg::MAX_SCALE);
      end else begin
         sy_eff = SCW'(cfg.scale_y);
      end
   end

   // Item coordinates as signed canvas values
   assign px_s = CW'($signed({1'b0, item_ff.pix_x}));
   assign py_s = CW'($signed({1'b0, item_ff.pix_y}));

   // Clip window of the replicated block
   always_comb begin
      xe = bx_ff + CW'($signed({1'b0, sx_eff}));
      ye = by_ff + CW'($signed({1'b0, sy_eff}));
      x0 = (bx_ff < 0) ? '0 : bx_ff;
      y0 = (by_ff < 0) ? '0 : by_ff;
      x1 = (xe > w_eff) ? w_eff : xe;
      y1 = (ye > h_eff) ? h_eff : ye;
   end

   // Channel select for the shared blend unit
   always_comb begin
      unique case (ch_ff)
         CH_RED:   begin mix_src = item_ff.red;   mix_dst = fb_rdata.red;   end
         CH_GREEN: begin mix_src = item_ff.green; mix_dst = fb_rdata.green; end
         default:  begin mix_src = item_ff.blue;  mix_dst = fb_rdata.blue;  end
      endcase
   end

   // Colour of the beat and last flag in the write cycle
   always_comb begin
      unique case (item_ff.operation)
         sab_pkg::OP_BLEND: emit_pix = res_ff;
         sab_pkg::OP_LOAD:  emit_pix = '{item_ff.red, item_ff.green, item_ff.blue};
         default:           emit_pix = fb_rdata;
      endcase
      pix_last = (item_ff.operation != sab_pkg::OP_BLEND) ||
                 ((cur_x_ff == x_hi_ff) && (cur_y_ff == y_hi_ff));
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      x_hi_in      = x_hi_ff;
      y_lo_in      = y_lo_ff;
      y_hi_in      = y_hi_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      ch_in        = ch_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fb_req.rd_en = 1'b0;
      fb_req.wr_en = 1'b0;
      fb_req.addr  = sab_pkg::FB_AW'(cur_y_ff) * sab_pkg::FB_AW'(sab_pkg::MAX_WIDTH)
                   + sab_pkg::FB_AW'(cur_x_ff);
      fb_req.wdata = emit_pix;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            bx_in    = CW'(px_s * CW'($signed({1'b0, sx_eff}))) + CW'(cfg.pos_x);
            by_in    = CW'(py_s * CW'($signed({1'b0, sy_eff}))) + CW'(cfg.pos_y);
            cur_x_in = XW'(item_ff.pix_x);
            cur_y_in = YW'(item_ff.pix_y);
            priority if (item_ff.operation == sab_pkg::OP_BLEND) begin
               state_in = ST_CLIP;
            end else if ((px_s >= w_eff) || (py_s >= h_eff)) begin
               state_in = ST_IDLE;
            end else if (item_ff.operation == sab_pkg::OP_LOAD) begin
               state_in = ST_EMIT;
            end else if (item_ff.operation == sab_pkg::OP_READ) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLIP: begin
            x_hi_in  = XW'(x1 - CW'(1));
            y_lo_in  = YW'(y0);
            y_hi_in  = YW'(y1 - CW'(1));
            cur_x_in = XW'(x0);
            cur_y_in = YW'(y0);
            state_in = ((x0 < x1) && (y0 < y1)) ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            fb_req.rd_en = 1'b1;
            ch_in        = CH_RED;
            state_in     = (item_ff.operation == sab_pkg::OP_BLEND) ? ST_MIX : ST_EMIT;
         end
         ST_MIX: begin
            unique case (ch_ff)
               CH_RED:   res_in.red   = mix_out;
               CH_GREEN: res_in.green = mix_out;
               default:  res_in.blue  = mix_out;
            endcase
            if (ch_ff == CH_BLUE) begin
               state_in = ST_EMIT;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               fb_req.wr_en     = (item_ff.operation != sab_pkg::OP_READ);
               rsp_in.out_x     = 8'(cur_x_ff);
               rsp_in.out_y     = 8'(cur_y_ff);
               rsp_in.out_red   = emit_pix.red;
               rsp_in.out_green = emit_pix.green;
               rsp_in.out_blue  = emit_pix.blue;
               rsp_in.last      = pix_last;
               rsp_valid_in     = 1'b1;
               if (pix_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD;
                  // row offset inner, column offset outer
                  if (cur_y_ff == y_hi_ff) begin
                     cur_y_in = y_lo_ff;
                     cur_x_in = cur_x_ff + 1'b1;
                  end else begin
                     cur_y_in = cur_y_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= CH_RED;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ch_ff        <= ch_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      x_hi_ff  <= x_hi_in;
      y_lo_ff  <= y_lo_in;
      y_hi_ff  <= y_hi_in;
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // A new beat only comes out of the write cycle
   a_beat_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response beat raised outside the write cycle");

   // Emitted pixels lie inside the active canvas
   a_beat_in_canvas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((CW'(rsp_ff.out_x) < w_eff) && (CW'(rsp_ff.out_y) < h_eff)))
      else $error("response pixel outside the canvas");

   // Blend pass walks only the three colour channels
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |-> (ch_ff == CH_RED || ch_ff == CH_GREEN || ch_ff == CH_BLUE))
      else $error("blend channel counter out of range");

   // The last beat of an item returns the sequencer to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && pix_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after the last beat");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   // Code the package leaves unnamed: the block ignores it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Cycles to let pass after the last response before touching the registers
   localparam int SETTLE_CYCLES = 400;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 28;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   sab_pkg::req_type            req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   sab_pkg::rsp_type            rsp_data;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [sab_pkg::CSR_AW-1:0]  paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   scaled_alpha_blit_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   // Shadow of the block: framebuffer and layer registers
   sab_pkg::pix_type   fb_model [sab_pkg::FB_DEPTH];
   logic signed [12:0] cfg_pos_x;
   logic signed [12:0] cfg_pos_y;
   logic [3:0]         cfg_scale_x;
   logic [3:0]         cfg_scale_y;
   logic [8:0]         cfg_canvas_w;
   logic [8:0]         cfg_canvas_h;

   sab_pkg::req_type blit_req_q [$];
   sab_pkg::rsp_type pixel_expect_q [$];
   sab_pkg::rsp_type due_beat;

   logic req_beat_taken = 1'b0;
   logic quiet = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;

   int mismatch_count = 0;
   int rsp_checked = 0;
   int blend_beats = 0;
   int load_beats = 0;
   int read_beats = 0;
   int unused_beats = 0;
   int layer_settings = 0;

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, predicted %0d (x %0d y %0d)",
                                   name, got, want, due_beat.out_x, due_beat.out_y));
      end
   endtask

   function automatic int eff_scale(logic [3:0] s);
      if (s == 0) return 1;
      if (s > sab_pkg::MAX_SCALE) return sab_pkg::MAX_SCALE;
      return int'(s);
   endfunction

   function automatic int eff_size(logic [8:0] s, int maxv);
      return (int'(s) > maxv) ? maxv : int'(s);
   endfunction

   function automatic logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int t;
      t = int'(s) * int'(a) + int'(d) * (255 - int'(a));
      return 8'(t / 255);
   endfunction

   // Expected response beats for one request beat; updates the shadow framebuffer
   function automatic void predict_blit(sab_pkg::req_type item);
      int               w, h, sx, sy, bx, by, x, y, idx, n;
      sab_pkg::pix_type d, c;
      sab_pkg::rsp_type beat;
      w = eff_size(cfg_canvas_w, sab_pkg::MAX_WIDTH);
      h = eff_size(cfg_canvas_h, sab_pkg::MAX_HEIGHT);
      n = 0;
      case (item.operation)
         sab_pkg::OP_BLEND: begin
            blend_beats++;
            sx = eff_scale(cfg_scale_x);
            sy = eff_scale(cfg_scale_y);
            bx = int'(item.pix_x) * sx + int'(cfg_pos_x);
            by = int'(item.pix_y) * sy + int'(cfg_pos_y);
            // column offset outer, row offset inner
            for (int xs = 0; xs < sx; xs++) begin
               for (int ys = 0; ys < sy; ys++) begin
                  x = bx + xs;
                  y = by + ys;
                  if (x >= 0 && x < w && y >= 0 && y < h) begin
                     idx = y * sab_pkg::MAX_WIDTH + x;
                     d = fb_model[idx];
                     c.red   = mix_channel(item.red, d.red, item.alpha);
                     c.green = mix_channel(item.green, d.green, item.alpha);
                     c.blue  = mix_channel(item.blue, d.blue, item.alpha);
                     fb_model[idx] = c;
                     beat = '{out_x: 8'(x), out_y: 8'(y), out_red: c.red,
                              out_green: c.green, out_blue: c.blue, last: 1'b0};
                     pixel_expect_q = {pixel_expect_q, beat};
                     n++;
                  end
               end
            end
            if (n > 0) pixel_expect_q[pixel_expect_q.size() - 1].last = 1'b1;
         end
         sab_pkg::OP_LOAD, sab_pkg::OP_READ: begin
            if (item.operation == sab_pkg::OP_LOAD) load_beats++;
            else read_beats++;
            if (int'(item.pix_x) < w && int'(item.pix_y) < h) begin
               idx = int'(item.pix_y) * sab_pkg::MAX_WIDTH + int'(item.pix_x);
               if (item.operation == sab_pkg::OP_LOAD) begin
                  fb_model[idx] = '{red: item.red, green: item.green, blue: item.blue};
               end
               c = fb_model[idx];
               beat = '{out_x: item.pix_x[7:0], out_y: item.pix_y[7:0], out_red: c.red,
                        out_green: c.green, out_blue: c.blue, last: 1'b1};
               pixel_expect_q = {pixel_expect_q, beat};
            end
         end
         default: unused_beats++;
      endcase
   endfunction

   // Sampling: register writes, accepted request beats, response check
   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[sab_pkg::CSR_AW-1:2])
               sab_pkg::REG_POS_X:    cfg_pos_x    = pwdata[12:0];
               sab_pkg::REG_POS_Y:    cfg_pos_y    = pwdata[12:0];
               sab_pkg::REG_SCALE_X:  cfg_scale_x  = pwdata[3:0];
               sab_pkg::REG_SCALE_Y:  cfg_scale_y  = pwdata[3:0];
               sab_pkg::REG_CANVAS_W: cfg_canvas_w = pwdata[8:0];
               sab_pkg::REG_CANVAS_H: cfg_canvas_h = pwdata[8:0];
               default: ;
            endcase
         end
         req_beat_taken = req_valid && !req_stall;
         if (req_beat_taken) predict_blit(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pixel_expect_q.size() == 0) begin
               report_mismatch($sformatf("response beat x %0d y %0d with nothing pending",
                                         rsp_data.out_x, rsp_data.out_y));
            end else begin
               due_beat = pixel_expect_q.pop_front();
               rsp_checked++;
               check_field("out_x", rsp_data.out_x, due_beat.out_x);
               check_field("out_y", rsp_data.out_y, due_beat.out_y);
               check_field("out_red", rsp_data.out_red, due_beat.out_red);
               check_field("out_green", rsp_data.out_green, due_beat.out_green);
               check_field("out_blue", rsp_data.out_blue, due_beat.out_blue);
               check_field("last", 8'(rsp_data.last), 8'(due_beat.last));
            end
         end
      end
   end

   // Request driver: next beat after acceptance, random idle bursts between beats
   always @(negedge clock) begin
      if (!req_valid || req_beat_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (blit_req_q.size() > 0 && !quiet && $urandom_range(0, 3) == 0) begin
            req_gap = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (blit_req_q.size() > 0) begin
            req_data  <= blit_req_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random stall bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_hold = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Register write: setup cycle, access cycle, done once pready is seen
   task automatic write_reg(logic [2:0] idx, int value, int width);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value & ((1 << width) - 1);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_layer(int px, int py, int sx, int sy, int w, int h);
      write_reg(sab_pkg::REG_POS_X, px, 13);
      write_reg(sab_pkg::REG_POS_Y, py, 13);
      write_reg(sab_pkg::REG_SCALE_X, sx, 4);
      write_reg(sab_pkg::REG_SCALE_Y, sy, 4);
      write_reg(sab_pkg::REG_CANVAS_W, w, 9);
      write_reg(sab_pkg::REG_CANVAS_H, h, 9);
      layer_settings++;
   endtask

   task automatic push_item(logic [1:0] op, int x, int y, int r, int g, int b, int a);
      sab_pkg::req_type item;
      item = '{operation: op, pix_x: 10'(x), pix_y: 10'(y), red: 8'(r),
               green: 8'(g), blue: 8'(b), alpha: 8'(a)};
      blit_req_q = {blit_req_q, item};
   endtask

   // Sender holds off until everything is in and out, then lets the block go idle
   task automatic settle_phase();
      int waited;
      while (blit_req_q.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (pixel_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pixel_expect_q.size() != 0) begin
         report_mismatch($sformatf("%0d predicted response beats never arrived",
                                   pixel_expect_q.size()));
         pixel_expect_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_pos();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return -4096;
      if (r == 1) return 4095;
      if (r == 2) return int'($urandom_range(0, 8191)) - 4096;
      return int'($urandom_range(0, 24)) - 8;
   endfunction

   function automatic int pick_scale();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(9, 15));
      if (r < 3) return int'($urandom_range(4, 8));
      return int'($urandom_range(1, 3));
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return int'($urandom_range(0, 1));
      if (r == 1) return int'($urandom_range(257, 511));
      if (r < 4) return 256;
      return int'($urandom_range(4, 32));
   endfunction

   function automatic int clamp_pix(int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
   endfunction

   // Mostly on-canvas blends, loads and reads under the current layer; some noise
   task automatic push_random_item();
      int               r, w, h, sx, sy, px, py, a;
      logic [63:0]      raw;
      sab_pkg::req_type item;
      w  = eff_size(cfg_canvas_w, sab_pkg::MAX_WIDTH);
      h  = eff_size(cfg_canvas_h, sab_pkg::MAX_HEIGHT);
      sx = eff_scale(cfg_scale_x);
      sy = eff_scale(cfg_scale_y);
      r  = $urandom_range(0, 99);
      if (r < 8) begin
         raw  = {$urandom(), $urandom()};
         item = raw[$bits(sab_pkg::req_type)-1:0];
         blit_req_q = {blit_req_q, item};
      end else if (r < 55) begin
         px = (int'($urandom_range(0, w + 1)) - 1 - int'(cfg_pos_x)) / sx;
         py = (int'($urandom_range(0, h + 1)) - 1 - int'(cfg_pos_y)) / sy;
         case ($urandom_range(0, 9))
            0:       a = 0;
            1:       a = 255;
            default: a = $urandom_range(0, 255);
         endcase
         push_item(sab_pkg::OP_BLEND, clamp_pix(px), clamp_pix(py), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), a);
      end else if (r < 96) begin
         if ($urandom_range(0, 9) == 0 || w == 0 || h == 0) begin
            px = $urandom_range(0, 1023);
            py = $urandom_range(0, 1023);
         end else begin
            px = $urandom_range(0, w - 1);
            py = $urandom_range(0, h - 1);
         end
         push_item((r < 75) ? sab_pkg::OP_LOAD : sab_pkg::OP_READ, px, py,
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
      end else begin
         push_item(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
      end
   endtask

   initial begin
      foreach (fb_model[i]) fb_model[i] = '0;
      cfg_pos_x    = '0;
      cfg_pos_y    = '0;
      cfg_scale_x  = 4'd1;
      cfg_scale_y  = 4'd1;
      cfg_canvas_w = 9'd256;
      cfg_canvas_h = 9'd256;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset layer settings: corners, out-of-canvas access, unused code, alpha ends
      push_item(sab_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
      push_item(sab_pkg::OP_LOAD, 0, 0, 255, 0, 128, 0);
      push_item(sab_pkg::OP_LOAD, 255, 255, 18, 52, 86, 0);
      push_item(sab_pkg::OP_READ, 255, 255, 0, 0, 0, 0);
      push_item(sab_pkg::OP_LOAD, 256, 5, 1, 2, 3, 0);
      push_item(sab_pkg::OP_READ, 3, 1023, 0, 0, 0, 0);
      push_item(OP_UNUSED, 0, 0, 255, 255, 255, 255);
      push_item(sab_pkg::OP_BLEND, 0, 0, 0, 255, 0, 128);
      push_item(sab_pkg::OP_BLEND, 255, 255, 200, 100, 50, 0);
      push_item(sab_pkg::OP_BLEND, 255, 255, 255, 255, 255, 255);
      push_item(sab_pkg::OP_BLEND, 1023, 1023, 9, 9, 9, 9);
      settle_phase();

      // Uneven scale with negative offset: order of covered pixels, fully clipped block
      set_layer(-3, -2, 2, 3, 256, 256);
      push_item(sab_pkg::OP_BLEND, 2, 1, 90, 180, 240, 200);
      push_item(sab_pkg::OP_BLEND, 0, 0, 1, 2, 3, 255);
      settle_phase();

      // Largest scale, partial clip on both edges, oversize width
      set_layer(-4, -4, 8, 8, 511, 256);
      push_item(sab_pkg::OP_BLEND, 0, 0, 40, 80, 120, 77);
      push_item(sab_pkg::OP_BLEND, 31, 31, 250, 5, 130, 161);
      push_item(sab_pkg::OP_BLEND, 32, 32, 17, 34, 51, 254);
      settle_phase();

      // Scale zero and scale above the maximum, one-column canvas
      set_layer(0, 0, 0, 15, 1, 256);
      push_item(sab_pkg::OP_BLEND, 0, 2, 66, 77, 88, 99);
      push_item(sab_pkg::OP_LOAD, 1, 0, 5, 6, 7, 0);
      push_item(sab_pkg::OP_LOAD, 0, 0, 5, 6, 7, 0);
      settle_phase();

      // Empty canvas, offsets at the extremes
      set_layer(4095, -4096, 1, 1, 0, 0);
      push_item(sab_pkg::OP_BLEND, 0, 0, 10, 20, 30, 40);
      push_item(sab_pkg::OP_LOAD, 0, 0, 10, 20, 30, 40);
      push_item(sab_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
      settle_phase();

      // Most negative offsets brought back on canvas by large layer coordinates
      set_layer(-4096, -4096, 8, 8, 256, 256);
      push_item(sab_pkg::OP_BLEND, 512, 543, 123, 45, 210, 180);
      push_item(sab_pkg::OP_BLEND, 1023, 1023, 1, 1, 1, 1);
      settle_phase();

      // Random layers; the last ones run with no idling on either side
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p >= RANDOM_PHASES - 2) quiet = 1'b1;
         set_layer(pick_pos(), pick_pos(), pick_scale(), pick_scale(), pick_size(),
                   pick_size());
         repeat (PHASE_ITEMS) push_random_item();
         settle_phase();
      end

      $display("Checked %0d response beats against predicted framebuffer writes and reads",
               rsp_checked);
      $display("Request beats: %0d blend, %0d load, %0d read, %0d unused code; %0d layers",
               blend_beats, load_beats, read_beats, unused_beats, layer_settings);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: scaled_alpha_blit_core.f
hdl/sab_pkg.sv
hdl/sab_csr.sv
hdl/sab_mix.sv
hdl/sab_fb.sv
hdl/scaled_alpha_blit_core.sv
dv/tb.sv
